// ===== hdl/b64c_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_pkg: shared types, constants and functions
// Base64 alphabet mapping, CRC-16 byte update and the character group type
// passed from the byte front end to the character back end.
// ----------------------------------------------------------------------------
package b64c_pkg;

    // Chunk numbering bound and derived counter width
    localparam int unsigned MAX_CHUNKS = 1024;
    localparam int unsigned CNT_W      = (MAX_CHUNKS > 2) ? $clog2(MAX_CHUNKS) : 1;

    localparam logic [7:0]  CHUNK_CHARS_RESET = 8'd120;
    localparam logic [15:0] CRC_INIT          = 16'hffff;
    localparam logic [15:0] CRC_POLY          = 16'h8408;
    localparam logic [6:0]  PAD_CHAR          = 7'h3d;
    localparam logic [1:0]  LAST_SLOT         = 2'd3;

    // Four characters of one base64 group, first character in slot 0
    typedef struct packed {
        logic [3:0][6:0] chars;
        logic            last;
    } group_t;

    // Group queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Map a 6-bit code to its base64 ASCII character
    function automatic logic [6:0] b64_char(input logic [5:0] code);
        logic [6:0] c;
        begin
            c = {1'b0, code};
            if (code < 6'd26)
                b64_char = 7'h41 + c;
            else if (code < 6'd52)
                b64_char = 7'h61 + c - 7'd26;
            else if (code < 6'd62)
                b64_char = 7'h30 + c - 7'd52;
            else if (code == 6'd62)
                b64_char = 7'h2b;
            else
                b64_char = 7'h2f;
        end
    endfunction

    // Reflected CRC-16 update with one character
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [6:0] ch);
        logic [15:0] c;
        begin
            c = crc ^ {9'd0, ch};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            crc_feed = c;
        end
    endfunction

endpackage

// ===== hdl/b64c_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_front: byte collector and base64 group builder
// Holds up to two pending bytes and turns each completed or final group
// into four ASCII characters with padding.
// ----------------------------------------------------------------------------
module b64c_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    input  logic              last_byte,
    output logic              grp_push,
    output b64c_pkg::group_t  grp_data
);

    logic [15:0] held_bytes_reg, held_bytes_next;
    logic [1:0]  held_count_reg, held_count_next;
    logic [1:0]  count;
    logic [1:0]  total;
    logic [23:0] v;

    // Build the group word and decide whether it is complete
    always_comb
    begin
        count = (held_count_reg > 2'd2) ? 2'd2 : held_count_reg;
        total = count + 2'd1;
        unique case (total)
            2'd1:    v = {in_byte, 16'd0};
            2'd2:    v = {held_bytes_reg[7:0], in_byte, 8'd0};
            default: v = {held_bytes_reg, in_byte};
        endcase
        grp_data.chars[0] = b64c_pkg::b64_char(v[23:18]);
        grp_data.chars[1] = b64c_pkg::b64_char(v[17:12]);
        grp_data.chars[2] = (total >= 2'd2) ? b64c_pkg::b64_char(v[11:6])
                                            : b64c_pkg::PAD_CHAR;
        grp_data.chars[3] = (total == 2'd3) ? b64c_pkg::b64_char(v[5:0])
                                            : b64c_pkg::PAD_CHAR;
        grp_data.last     = last_byte;
        grp_push          = in_valid && (last_byte || total == 2'd3);

        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        if (in_valid)
        begin
            if (grp_push)
            begin
                held_bytes_next = 16'd0;
                held_count_next = 2'd0;
            end
            else
            begin
                held_bytes_next = {held_bytes_reg[7:0], in_byte};
                held_count_next = total;
            end
        end
    end

    // Hold pending bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bytes_reg <= 16'd0;
            held_count_reg <= 2'd0;
        end
        else
        begin
            held_bytes_reg <= held_bytes_next;
            held_count_reg <= held_count_next;
        end
    end

endmodule

// ===== hdl/b64c_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_fifo: two-entry group queue
// Decouples the byte front end from the character back end.
// ----------------------------------------------------------------------------
module b64c_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b64c_pkg::group_t  wdata,
    input  logic              pop,
    output b64c_pkg::group_t  rdata,
    output b64c_pkg::qstat_t  stat
);

    b64c_pkg::group_t mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;

    // Pointer and fill count update
    always_comb
    begin
        stat.full  = (cnt_reg == 2'd2);
        stat.empty = (cnt_reg == 2'd0);
        do_push    = push && !stat.full;
        do_pop     = pop && !stat.empty;
        wptr_next  = do_push ? !wptr_reg : wptr_reg;
        rptr_next  = do_pop ? !rptr_reg : rptr_reg;
        cnt_next   = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        rdata      = mem_reg[rptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wptr_reg] <= wdata;
    end

endmodule

// ===== hdl/b64c_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_back: character serializer with chunk CRC
// Emits one current-group character per unstalled cycle, runs the chunk
// CRC and character count, and holds each result in an output register.
// ----------------------------------------------------------------------------
module b64c_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        chunk_chars,
    input  b64c_pkg::group_t  grp_data,
    input  b64c_pkg::qstat_t  q_stat,
    output logic              grp_pop,
    input  logic              pop,
    output logic              empty,
    output logic [6:0]        out_char,
    output logic              chunk_end,
    output logic [15:0]       chunk_crc,
    output logic [9:0]        chunk_number,
    output logic              run_last
);

    localparam int unsigned CNT_W = b64c_pkg::CNT_W;

    b64c_pkg::group_t grp_reg, grp_next;
    logic             busy_reg, busy_next;
    logic [1:0]       idx_reg, idx_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       nchars_reg, nchars_next;
    logic [CNT_W-1:0] chunk_reg, chunk_next;

    logic             ov_reg, ov_next;
    logic [6:0]       ochar_reg, ochar_next;
    logic             oend_reg, oend_next;
    logic [15:0]      ocrc_reg, ocrc_next;
    logic [9:0]       onum_reg, onum_next;
    logic             olast_reg, olast_next;

    logic             emit;
    logic             msg_end;
    logic             close;
    logic [6:0]       ch;
    logic [15:0]      crc_new;
    logic [7:0]       nchars_inc;
    logic [31:0]      chunk_ext;

    // Emit one character and advance chunk state
    always_comb
    begin
        emit       = busy_reg && (!ov_reg || pop);
        ch         = grp_reg.chars[idx_reg];
        msg_end    = grp_reg.last && (idx_reg == b64c_pkg::LAST_SLOT);
        crc_new    = b64c_pkg::crc_feed(crc_reg, ch);
        nchars_inc = nchars_reg + 8'd1;
        close      = msg_end || (nchars_inc == chunk_chars);
        chunk_ext  = 32'(chunk_reg);

        grp_next    = grp_reg;
        busy_next   = busy_reg;
        idx_next    = idx_reg;
        crc_next    = crc_reg;
        nchars_next = nchars_reg;
        chunk_next  = chunk_reg;
        grp_pop     = 1'b0;

        ov_next    = ov_reg && !pop;
        ochar_next = ochar_reg;
        oend_next  = oend_reg;
        ocrc_next  = ocrc_reg;
        onum_next  = onum_reg;
        olast_next = olast_reg;

        if (emit)
        begin
            ov_next    = 1'b1;
            ochar_next = ch;
            oend_next  = close;
            ocrc_next  = close ? crc_new : 16'd0;
            onum_next  = chunk_ext[9:0];
            olast_next = (idx_reg == b64c_pkg::LAST_SLOT);
            idx_next   = idx_reg + 2'd1;
            if (close)
            begin
                crc_next    = b64c_pkg::CRC_INIT;
                nchars_next = 8'd0;
                chunk_next  = (chunk_reg == CNT_W'(b64c_pkg::MAX_CHUNKS - 1))
                              ? '0 : chunk_reg + 1'b1;
            end
            else
            begin
                crc_next    = crc_new;
                nchars_next = nchars_inc;
            end
            // Message end clears chunk state
            if (msg_end)
            begin
                crc_next    = b64c_pkg::CRC_INIT;
                nchars_next = 8'd0;
                chunk_next  = '0;
            end
            if (idx_reg == b64c_pkg::LAST_SLOT)
                busy_next = 1'b0;
        end

        // Load the next group when idle or finishing the current one
        if ((!busy_reg || (emit && idx_reg == b64c_pkg::LAST_SLOT)) && !q_stat.empty)
        begin
            grp_pop   = 1'b1;
            grp_next  = grp_data;
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end

        empty        = !ov_reg;
        out_char     = ochar_reg;
        chunk_end    = oend_reg;
        chunk_crc    = ocrc_reg;
        chunk_number = onum_reg;
        run_last     = olast_reg;
    end

    // Control and chunk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            idx_reg    <= 2'd0;
            crc_reg    <= b64c_pkg::CRC_INIT;
            nchars_reg <= 8'd0;
            chunk_reg  <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            idx_reg    <= idx_next;
            crc_reg    <= crc_next;
            nchars_reg <= nchars_next;
            chunk_reg  <= chunk_next;
            ov_reg     <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        grp_reg   <= grp_next;
        ochar_reg <= ochar_next;
        oend_reg  <= oend_next;
        ocrc_reg  <= ocrc_next;
        onum_reg  <= onum_next;
        olast_reg <= olast_next;
    end

endmodule

// ===== hdl/base64_chunk_crc_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_chunk_crc_encoder: streaming base64 encoder with chunk CRC-16
//
// Input queue side: drive in_byte and last_byte with push; a byte transfers
// when push is high and full is low. last_byte ends the message, flushes the
// pending group with '=' padding and closes the current chunk.
// Result queue side: while empty is low the oldest character sits on
// out_char with chunk_end, chunk_crc, chunk_number and run_last; it
// transfers when pop is high. Stalling on pop only holds the output
// register; the front keeps taking bytes until the two-entry group queue
// fills, then full rises.
// A group-completing byte passes the group queue and the serializer group
// register before reaching the output register. The single CRC/serializer
// stage emits one character per cycle while groups wait and pop keeps up.
// cfg_we/cfg_wdata write the chunk length (reset 120, 0 means 256); write
// only while idle. Reset clears the control and chunk state; the first
// message starts at chunk 0.
// ----------------------------------------------------------------------------
module base64_chunk_crc_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [6:0]  out_char,
    output logic        chunk_end,
    output logic [15:0] chunk_crc,
    output logic [9:0]  chunk_number,
    output logic        run_last
);

    logic [7:0]        chunk_chars_reg, chunk_chars_next;
    logic              in_valid;
    logic              grp_push;
    logic              grp_pop;
    b64c_pkg::group_t  grp_wdata;
    b64c_pkg::group_t  grp_rdata;
    b64c_pkg::qstat_t  q_stat;

    // Chunk length register
    always_comb
    begin
        chunk_chars_next = cfg_we ? cfg_wdata : chunk_chars_reg;
        full             = q_stat.full;
        in_valid         = push && !q_stat.full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chunk_chars_reg <= b64c_pkg::CHUNK_CHARS_RESET;
        else
            chunk_chars_reg <= chunk_chars_next;
    end

    b64c_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .last_byte (last_byte),
        .grp_push  (grp_push),
        .grp_data  (grp_wdata)
    );

    b64c_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (grp_push),
        .wdata (grp_wdata),
        .pop   (grp_pop),
        .rdata (grp_rdata),
        .stat  (q_stat)
    );

    b64c_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .chunk_chars  (chunk_chars_reg),
        .grp_data     (grp_rdata),
        .q_stat       (q_stat),
        .grp_pop      (grp_pop),
        .pop          (pop),
        .empty        (empty),
        .out_char     (out_char),
        .chunk_end    (chunk_end),
        .chunk_crc    (chunk_crc),
        .chunk_number (chunk_number),
        .run_last     (run_last)
    );

endmodule

// ===== hdl/b64c_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_checker: port-level checks for the encoder
// Watches the result queue side for stalled holds and result consistency.
// ----------------------------------------------------------------------------
module b64c_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  logic        pop,
    input  logic [6:0]  out_char,
    input  logic        chunk_end,
    input  logic [15:0] chunk_crc,
    input  logic        run_last
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(chunk_crc)))
        else $error("stalled result changed");

    // Report a CRC only on a chunk-closing character
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !chunk_end) |-> (chunk_crc == 16'd0))
        else $error("CRC on non-closing character");

    // Padding in the last slot always ends the message and its chunk
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && run_last && out_char == b64c_pkg::PAD_CHAR) |-> chunk_end)
        else $error("padded group did not close chunk");

endmodule

bind base64_chunk_crc_encoder b64c_checker u_b64c_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .out_char  (out_char),
    .chunk_end (chunk_end),
    .chunk_crc (chunk_crc),
    .run_last  (run_last)
);
